FILE: src/tape_image_record_scanner_macros.svh
// Assertion macros shared by the tape image record scanner RTL
`ifndef TAPE_IMAGE_RECORD_SCANNER_MACROS_SVH
`define TAPE_IMAGE_RECORD_SCANNER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define TIRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
// next-cycle implication, disabled during reset
`define TIRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define TIRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TIRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/tirs_pkg.sv
// Shared types and helpers for the tape image record scanner
package tirs_pkg;

	// report kinds
	typedef enum logic [1:0] {
		KIND_RUN           = 2'd0,
		KIND_FILE_END      = 2'd1,
		KIND_SECOND_MARK   = 2'd2,
		KIND_END_OF_MEDIUM = 2'd3
	} kind_t;

	// one report request
	typedef struct packed {
		kind_t        kind;
		logic [15:0]  file_number;
		logic [23:0]  first_record;
		logic [23:0]  last_record;
		logic [39:0]  byte_count;
		logic         last_of_run;
	} res_t;

	// reports produced by one accepted byte, first is the older one
	typedef struct packed {
		logic [1:0] count;
		res_t       first;
		res_t       second;
	} push_t;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	function automatic res_t make_res(kind_t k, logic [15:0] fnum, logic [23:0] first,
		logic [23:0] last, logic [39:0] bytes);
		res_t r;
		r.kind         = k;
		r.file_number  = fnum;
		r.first_record = first;
		r.last_record  = last;
		r.byte_count   = bytes;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

FILE: src/tirs_if.sv
// Handshake channels for image bytes and reports

interface tirs_byte_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] byte_value;

	modport source (output valid, output mode, output byte_value, input ready);
	modport sink (input valid, input mode, input byte_value, output ready);
endinterface

interface tirs_report_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] file_number;
	logic [23:0] first_record;
	logic [23:0] last_record;
	logic [39:0] byte_count;
	logic        last_of_run;

	modport source (output valid, output kind, output file_number, output first_record,
		output last_record, output byte_count, output last_of_run, input ready);
	modport sink (input valid, input kind, input file_number, input first_record,
		input last_record, input byte_count, input last_of_run, output ready);
endinterface

FILE: src/tirs_result_fifo.sv
// Report queue: takes up to two report requests a cycle, hands out one
`include "tape_image_record_scanner_macros.svh"

module tirs_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  tirs_pkg::push_t   push,
	output logic              room,
	tirs_report_if.source     reports
);

	tirs_pkg::res_t                  mem_q [tirs_pkg::QDepth];
	logic [tirs_pkg::QPtrW-1:0]      wr_ptr_q;
	logic [tirs_pkg::QPtrW-1:0]      rd_ptr_q;
	logic [tirs_pkg::QCntW-1:0]      count_q;
	logic                            pop;
	logic [tirs_pkg::QPtrW-1:0]      wr_ptr_p1;
	tirs_pkg::res_t                  head;

	assign pop       = reports.valid && reports.ready;
	assign wr_ptr_p1 = wr_ptr_q + {{(tirs_pkg::QPtrW-1){1'b0}}, 1'b1};
	// space for the worst case of two requests from one byte
	assign room      = count_q <= tirs_pkg::QCntW'(tirs_pkg::QDepth - 2);

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_p1] <= push.second;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tirs_pkg::QPtrW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + {{(tirs_pkg::QPtrW-1){1'b0}}, 1'b1};
			end
			count_q <= count_q + tirs_pkg::QCntW'(push.count)
				- tirs_pkg::QCntW'(pop);
		end
	end

	// head of queue drives the channel
	assign head                 = mem_q[rd_ptr_q];
	assign reports.valid        = count_q != '0;
	assign reports.kind         = head.kind;
	assign reports.file_number  = head.file_number;
	assign reports.first_record = head.first_record;
	assign reports.last_record  = head.last_record;
	assign reports.byte_count   = head.byte_count;
	assign reports.last_of_run  = head.last_of_run;

	`TIRS_ASSERT_NOW(a_no_overflow, clk, arst_n, 1'b1, count_q <= 3'd4)
	`TIRS_ASSERT_NOW(a_push_needs_room, clk, arst_n, push.count != 2'd0, room)
	`TIRS_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && push.count == 2'd0,
		count_q == $past(count_q) - 3'd1)

endmodule

FILE: src/tape_image_record_scanner.sv
// Tape image record scanner: one image byte per request, reports on a queued channel.
// The reports of a byte are registered into the queue and offered from its head.
// Throughput: one byte per cycle while the four-entry report queue has room for two.
// Up to two reports per byte; draining one per cycle while ready sets the limit.
// Reset: arst_n clears all state at once; file number restarts at one, nothing queued.
`include "tape_image_record_scanner_macros.svh"

module tape_image_record_scanner (
	input  logic          clk,
	input  logic          arst_n,
	tirs_byte_if.sink     bytes,
	tirs_report_if.source reports
);

	typedef enum logic [3:0] {
		PH_HEADER  = 4'b0001,
		PH_DATA    = 4'b0010,
		PH_PAD     = 4'b0100,
		PH_TRAILER = 4'b1000
	} phase_t;

	phase_t       phase_q, phase_n;
	logic [1:0]   idx_q, idx_n;
	logic [23:0]  hdr_q, hdr_n;
	logic [15:0]  rem_q, rem_n;
	logic [15:0]  len_q, len_n;
	logic [1:0]   mc_q, mc_n;
	logic [15:0]  fc_q, fc_n;
	logic [23:0]  rc_q, rc_n;
	logic [23:0]  rs_q, rs_n;
	logic [15:0]  rsize_q, rsize_n;
	logic         rvalid_q, rvalid_n;
	logic [31:0]  fb_q, fb_n;
	logic [39:0]  tot_q, tot_n;
	logic         fin_q, fin_n;

	logic             room;
	logic             acc;
	logic             do_eom, do_mark, do_record;
	logic [31:0]      h;
	logic [23:0]      rc_inc;
	logic [32:0]      fb_sum;
	logic [40:0]      tot_sum;
	tirs_pkg::push_t  push;

	assign bytes.ready = room;
	assign acc         = bytes.valid && bytes.ready;
	assign h           = {bytes.byte_value, hdr_q};
	assign rc_inc      = (rc_q == '1) ? rc_q : rc_q + 24'd1;
	assign fb_sum      = {1'b0, fb_q} + {17'b0, len_q};
	assign tot_sum     = {1'b0, tot_q} + {9'b0, fb_q};

	// next state and reports for one byte
	always_comb begin
		phase_n  = phase_q;
		idx_n    = idx_q;
		hdr_n    = hdr_q;
		rem_n    = rem_q;
		len_n    = len_q;
		mc_n     = mc_q;
		fc_n     = fc_q;
		rc_n     = rc_q;
		rs_n     = rs_q;
		rsize_n  = rsize_q;
		rvalid_n = rvalid_q;
		fb_n     = fb_q;
		tot_n    = tot_q;
		fin_n    = fin_q;
		do_eom    = 1'b0;
		do_mark   = 1'b0;
		do_record = 1'b0;
		push      = '0;

		// decode the byte against the framing phase
		if (acc && !fin_q) begin
			if (bytes.mode) begin
				do_eom = 1'b1;
			end else begin
				unique case (phase_q)
					PH_HEADER: begin
						if (idx_q == 2'd3) begin
							idx_n = 2'd0;
							hdr_n = '0;
							if (h[31:16] != 16'd0) begin
								do_eom = 1'b1;
							end else if (h == 32'd0) begin
								do_mark = 1'b1;
							end else begin
								len_n   = h[15:0];
								rem_n   = h[15:0];
								phase_n = PH_DATA;
							end
						end else begin
							hdr_n[{idx_q, 3'b000} +: 8] = bytes.byte_value;
							idx_n = idx_q + 2'd1;
						end
					end
					PH_DATA: begin
						rem_n = rem_q - 16'd1;
						if (rem_q == 16'd1) begin
							if (len_q[0]) begin
								phase_n = PH_PAD;
							end else begin
								do_record = 1'b1;
							end
						end
					end
					PH_PAD: begin
						do_record = 1'b1;
					end
					PH_TRAILER: begin
						idx_n = idx_q + 2'd1;
						if (idx_q == 2'd3) begin
							phase_n = PH_HEADER;
							hdr_n   = '0;
						end
					end
					default: begin
						phase_n = phase_q;
					end
				endcase
			end
		end

		// end of medium: report tape total, then ignore everything
		if (do_eom) begin
			fin_n       = 1'b1;
			push.count  = 2'd1;
			push.first  = tirs_pkg::make_res(tirs_pkg::KIND_END_OF_MEDIUM, 16'd0, 24'd0,
				24'd0, tot_q);
		end

		// record complete: count it and open a new run on the first record or a size change
		if (do_record) begin
			rc_n    = rc_inc;
			fb_n    = fb_sum[32] ? '1 : fb_sum[31:0];
			mc_n    = 2'd0;
			phase_n = PH_TRAILER;
			idx_n   = 2'd0;
			if (!rvalid_q || len_q != rsize_q) begin
				if (rvalid_q) begin
					push.count = 2'd1;
					push.first = tirs_pkg::make_res(tirs_pkg::KIND_RUN, fc_q, rs_q, rc_q,
						{24'd0, rsize_q});
				end
				rsize_n  = len_q;
				rs_n     = rc_inc;
				rvalid_n = 1'b1;
			end
		end

		// tape mark: close the file, or note a repeated mark
		if (do_mark) begin
			mc_n = (mc_q == 2'd3) ? mc_q : mc_q + 2'd1;
			if (mc_q == 2'd0) begin
				if (rvalid_q) begin
					push.count  = 2'd2;
					push.first  = tirs_pkg::make_res(tirs_pkg::KIND_RUN, fc_q, rs_q, rc_q,
						{24'd0, rsize_q});
					push.second = tirs_pkg::make_res(tirs_pkg::KIND_FILE_END, fc_q, 24'd0,
						rc_q, {8'd0, fb_q});
				end else begin
					push.count = 2'd1;
					push.first = tirs_pkg::make_res(tirs_pkg::KIND_FILE_END, fc_q, 24'd0,
						rc_q, {8'd0, fb_q});
				end
				fc_n = (fc_q == '1) ? fc_q : fc_q + 16'd1;
			end else begin
				push.count = 2'd1;
				push.first = tirs_pkg::make_res(tirs_pkg::KIND_SECOND_MARK, fc_q, 24'd0,
					24'd0, {8'd0, fb_q});
			end
			tot_n    = tot_sum[40] ? '1 : tot_sum[39:0];
			rc_n     = '0;
			rs_n     = '0;
			fb_n     = '0;
			rvalid_n = 1'b0;
		end

		// flag the final report of this byte
		if (push.count == 2'd1) begin
			push.first.last_of_run = 1'b1;
		end else if (push.count == 2'd2) begin
			push.second.last_of_run = 1'b1;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			idx_q    <= '0;
			hdr_q    <= '0;
			rem_q    <= '0;
			len_q    <= '0;
			mc_q     <= '0;
			fc_q     <= 16'd1;
			rc_q     <= '0;
			rs_q     <= '0;
			rsize_q  <= '0;
			rvalid_q <= 1'b0;
			fb_q     <= '0;
			tot_q    <= '0;
			fin_q    <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			idx_q    <= idx_n;
			hdr_q    <= hdr_n;
			rem_q    <= rem_n;
			len_q    <= len_n;
			mc_q     <= mc_n;
			fc_q     <= fc_n;
			rc_q     <= rc_n;
			rs_q     <= rs_n;
			rsize_q  <= rsize_n;
			rvalid_q <= rvalid_n;
			fb_q     <= fb_n;
			tot_q    <= tot_n;
			fin_q    <= fin_n;
		end
	end

	tirs_result_fifo u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.reports (reports)
	);

	`TIRS_ASSERT_NEXT(a_finished_sticks, clk, arst_n, fin_q, fin_q)
	`TIRS_ASSERT_NOW(a_finished_silent, clk, arst_n, fin_q, push.count == 2'd0)

endmodule
